@@ rtl/core/ccirc_pkg.sv @@
// ---------------------------------------------------------------------------
// ccirc_pkg
// Shared widths and constants for the circumcircle pipeline.
// ---------------------------------------------------------------------------
package ccirc_pkg;

   localparam int IMAGE_WIDTH_C = 640;
   localparam int IMAGE_HEIGHT_C = 480;
   localparam int XW_C = $clog2(IMAGE_WIDTH_C);
   localparam int YW_C = $clog2(IMAGE_HEIGHT_C);

   // |nx| < 2^31 for 10/9 bit points, |det| < 2^22
   localparam int NUMW_C = 32;
   localparam int DETW_C = 23;
   localparam int QW_C = 32;
   // |dx|,|dy| < 2^31 + 2^10 -> squared sum below 2^64
   localparam int DW_C = 33;
   localparam int SQW_C = 64;
   localparam int RW_C = 32;

   typedef logic [31:0] word_type;

endpackage

@@ rtl/core/ccirc_front.sv @@
// ---------------------------------------------------------------------------
// ccirc_front
// Determinant and numerators over three registered stages.
// ---------------------------------------------------------------------------
module ccirc_front
   import ccirc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [XW_C-1:0]          ax,
   input  logic [YW_C-1:0]          ay,
   input  logic [XW_C-1:0]          bx,
   input  logic [YW_C-1:0]          by_coord,
   input  logic [XW_C-1:0]          cx,
   input  logic [YW_C-1:0]          cy,
   output logic                     out_valid,
   output logic signed [NUMW_C-1:0] nx,
   output logic signed [NUMW_C-1:0] ny,
   output logic signed [DETW_C-1:0] det,
   output logic signed [11:0]       x1
);

   // stage 1: differences and squares
   logic v1_ff;
   logic signed [11:0] dyb_ff, dyc_ff, dya_ff, dxb_ff, dxc_ff, dxa_ff;
   logic signed [11:0] x1_ff, x2_ff, x3_ff;
   logic signed [21:0] s1_ff, s2_ff, s3_ff;
   logic signed [21:0] s1_in, s2_in, s3_in;

   assign s1_in = 22'($unsigned(ax) * ax) + 22'($unsigned(ay) * ay);
   assign s2_in = 22'($unsigned(bx) * bx) + 22'($unsigned(by_coord) * by_coord);
   assign s3_in = 22'($unsigned(cx) * cx) + 22'($unsigned(cy) * cy);

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
      dyb_ff <= 12'(by_coord) - 12'(cy);
      dyc_ff <= 12'(cy) - 12'(ay);
      dya_ff <= 12'(ay) - 12'(by_coord);
      dxb_ff <= 12'(cx) - 12'(bx);
      dxc_ff <= 12'(ax) - 12'(cx);
      dxa_ff <= 12'(bx) - 12'(ax);
      x1_ff <= 12'(ax);
      x2_ff <= 12'(bx);
      x3_ff <= 12'(cx);
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   // stage 2: products
   logic v2_ff;
   logic signed [33:0] pn1_ff, pn2_ff, pn3_ff, pm1_ff, pm2_ff, pm3_ff;
   logic signed [23:0] pd1_ff, pd2_ff, pd3_ff;
   logic signed [11:0] x1b_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      pn1_ff <= 34'(s1_ff) * 34'(dyb_ff);
      pn2_ff <= 34'(s2_ff) * 34'(dyc_ff);
      pn3_ff <= 34'(s3_ff) * 34'(dya_ff);
      pm1_ff <= 34'(s1_ff) * 34'(dxb_ff);
      pm2_ff <= 34'(s2_ff) * 34'(dxc_ff);
      pm3_ff <= 34'(s3_ff) * 34'(dxa_ff);
      pd1_ff <= 24'(x1_ff) * 24'(dyb_ff);
      pd2_ff <= 24'(x2_ff) * 24'(dyc_ff);
      pd3_ff <= 24'(x3_ff) * 24'(dya_ff);
      x1b_ff <= x1_ff;
   end

   // stage 3: sums
   logic v3_ff;
   logic signed [NUMW_C-1:0] nx_ff, ny_ff;
   logic signed [DETW_C-1:0] det_ff;
   logic signed [11:0] x1c_ff;
   logic signed [33:0] nx_in, ny_in;
   logic signed [23:0] d_in;

   assign nx_in = pn1_ff + pn2_ff + pn3_ff;
   assign ny_in = pm1_ff + pm2_ff + pm3_ff;
   assign d_in  = pd1_ff + pd2_ff + pd3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      nx_ff <= NUMW_C'(nx_in);
      ny_ff <= NUMW_C'(ny_in);
      det_ff <= {d_in[DETW_C-2:0], 1'b0};
      x1c_ff <= x1b_ff;
   end

   assign out_valid = v3_ff;
   assign nx = nx_ff;
   assign ny = ny_ff;
   assign det = det_ff;
   assign x1 = x1c_ff;

endmodule

@@ rtl/core/ccirc_div.sv @@
// ---------------------------------------------------------------------------
// ccirc_div
// Pipelined restoring divider, one quotient bit per stage, truncating.
// ---------------------------------------------------------------------------
module ccirc_div
   import ccirc_pkg::*;
#(
   parameter int TAGW = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [NUMW_C-1:0] num,
   input  logic signed [DETW_C-1:0] den,
   input  logic [TAGW-1:0]          in_tag,
   output logic                     out_valid,
   output logic signed [QW_C-1:0]   quo,
   output logic [TAGW-1:0]          out_tag
);

   localparam int N = NUMW_C;

   logic              v_ff   [N+1];
   logic [N-1:0]      q_ff   [N+1];
   logic [DETW_C-1:0] r_ff   [N+1];
   logic [DETW_C-1:0] d_ff   [N+1];
   logic              neg_ff [N+1];
   logic [TAGW-1:0]   t_ff   [N+1];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= in_valid;
      q_ff[0] <= num[N-1] ? N'(-num) : N'(num);
      d_ff[0] <= den[DETW_C-1] ? DETW_C'(-den) : DETW_C'(den);
      r_ff[0] <= '0;
      neg_ff[0] <= num[N-1] ^ den[DETW_C-1];
      t_ff[0] <= in_tag;
   end

   for (genvar i = 0; i < N; i++) begin : g_st
      logic [DETW_C:0] sh, df;
      assign sh = {r_ff[i], q_ff[i][N-1]};
      assign df = sh - {1'b0, d_ff[i]};
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
         r_ff[i+1] <= df[DETW_C] ? sh[DETW_C-1:0] : df[DETW_C-1:0];
         q_ff[i+1] <= {q_ff[i][N-2:0], ~df[DETW_C]};
         d_ff[i+1] <= d_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         t_ff[i+1] <= t_ff[i];
      end
   end

   assign out_valid = v_ff[N];
   assign quo = neg_ff[N] ? QW_C'(-q_ff[N]) : QW_C'(q_ff[N]);
   assign out_tag = t_ff[N];

endmodule

@@ rtl/core/ccirc_sqrt.sv @@
// ---------------------------------------------------------------------------
// ccirc_sqrt
// Pipelined digit-by-digit floor square root, one root bit per stage.
// ---------------------------------------------------------------------------
module ccirc_sqrt
   import ccirc_pkg::*;
#(
   parameter int TAGW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [SQW_C-1:0]       rad,
   input  logic [TAGW-1:0]        in_tag,
   output logic                   out_valid,
   output logic [RW_C-1:0]        root,
   output logic [TAGW-1:0]        out_tag
);

   localparam int S = RW_C;

   logic             v_ff [S+1];
   logic [SQW_C-1:0] x_ff [S+1];
   logic [RW_C+1:0]  r_ff [S+1];
   logic [RW_C-1:0]  q_ff [S+1];
   logic [TAGW-1:0]  t_ff [S+1];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= in_valid;
      x_ff[0] <= rad;
      r_ff[0] <= '0;
      q_ff[0] <= '0;
      t_ff[0] <= in_tag;
   end

   for (genvar i = 0; i < S; i++) begin : g_st
      logic [RW_C+1:0] tr, tt;
      logic [RW_C+2:0] df;
      assign tr = {r_ff[i][RW_C-1:0], x_ff[i][SQW_C-1 -: 2]};
      assign tt = {q_ff[i], 2'b01};
      assign df = {1'b0, tr} - {1'b0, tt};
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
         x_ff[i+1] <= {x_ff[i][SQW_C-3:0], 2'b00};
         r_ff[i+1] <= df[RW_C+2] ? tr : df[RW_C+1:0];
         q_ff[i+1] <= {q_ff[i][RW_C-2:0], ~df[RW_C+2]};
         t_ff[i+1] <= t_ff[i];
      end
   end

   assign out_valid = v_ff[S];
   assign root = q_ff[S];
   assign out_tag = t_ff[S];

endmodule

@@ rtl/core/circumcircle_from_three_points.sv @@
// ---------------------------------------------------------------------------
// circumcircle_from_three_points
// Circumcenter by determinant formula and radius by floor square root.
//
//   channel  ports      handshake
//   req      req_*      start & !busy
//   rsp      rsp_*      rsp_valid, one cycle, no back pressure
//
// One word enters per cycle; busy is always low.
// A word passes the front, the dividers, the distance stages, the root
// pipeline and the output register; divider and root take one bit per stage.
// Reset clears only the valid bits.
// ---------------------------------------------------------------------------
module circumcircle_from_three_points
   import ccirc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [XW_C-1:0]        req_ax,
   input  logic [YW_C-1:0]        req_ay,
   input  logic [XW_C-1:0]        req_bx,
   input  logic [YW_C-1:0]        req_by_coord,
   input  logic [XW_C-1:0]        req_cx,
   input  logic [YW_C-1:0]        req_cy,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_center_x,
   output logic signed [31:0]     rsp_center_y,
   output logic [30:0]            rsp_circle_radius,
   output logic                   rsp_degenerate
);

   localparam int TW = 1 + 12 + QW_C;

   logic                     f_v;
   logic signed [NUMW_C-1:0] f_nx, f_ny;
   logic signed [DETW_C-1:0] f_det;
   logic signed [11:0]       f_x1;

   assign busy = 1'b0;

   ccirc_front u_front (
      .clock(clock), .reset(reset), .in_valid(start),
      .ax(req_ax), .ay(req_ay), .bx(req_bx),
      .by_coord(req_by_coord), .cx(req_cx), .cy(req_cy),
      .out_valid(f_v), .nx(f_nx), .ny(f_ny), .det(f_det), .x1(f_x1)
   );

   // y1 rides along the y divider tag
   logic signed [11:0] y1_ff [3];
   always_ff @(posedge clock) begin
      y1_ff[0] <= 12'(req_ay);
      y1_ff[1] <= y1_ff[0];
      y1_ff[2] <= y1_ff[1];
   end

   logic [12:0] dx_tag;
   logic [11:0] dy_tag;
   logic dv_x, dv_y;
   logic signed [QW_C-1:0] qx, qy;
   logic degen;
   assign degen = (f_det == '0);

   ccirc_div #(.TAGW(13)) u_divx (
      .clock(clock), .reset(reset), .in_valid(f_v), .num(f_nx),
      .den(degen ? DETW_C'(1) : f_det),
      .in_tag({degen, f_x1}), .out_valid(dv_x), .quo(qx), .out_tag(dx_tag)
   );
   ccirc_div #(.TAGW(12)) u_divy (
      .clock(clock), .reset(reset), .in_valid(f_v), .num(f_ny),
      .den(degen ? DETW_C'(1) : f_det),
      .in_tag(y1_ff[2]), .out_valid(dv_y), .quo(qy), .out_tag(dy_tag)
   );

   // distance stages
   logic v4_ff, v5_ff, v6_ff;
   logic signed [DW_C-1:0] ddx_ff, ddy_ff;
   logic [DW_C-2:0] adx_ff, ady_ff;
   logic [SQW_C-1:0] sq_ff;
   logic [TW-1:0] t4_ff, t5_ff, t6_ff;
   logic [QW_C-1:0] qy4_ff, qy5_ff, qy6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
      end else begin
         v4_ff <= dv_x; v5_ff <= v4_ff; v6_ff <= v5_ff;
      end
      ddx_ff <= DW_C'($signed(dx_tag[11:0])) - DW_C'(qx);
      ddy_ff <= DW_C'($signed(dy_tag)) - DW_C'(qy);
      t4_ff <= {dx_tag[12], 12'd0, qx};
      qy4_ff <= qy;
      adx_ff <= (DW_C-1)'(ddx_ff[DW_C-1] ? -ddx_ff : ddx_ff);
      ady_ff <= (DW_C-1)'(ddy_ff[DW_C-1] ? -ddy_ff : ddy_ff);
      t5_ff <= t4_ff; qy5_ff <= qy4_ff;
      sq_ff <= SQW_C'(adx_ff) * SQW_C'(adx_ff) + SQW_C'(ady_ff) * SQW_C'(ady_ff);
      t6_ff <= t5_ff; qy6_ff <= qy5_ff;
   end

   logic sv;
   logic [RW_C-1:0] rt;
   logic [TW+QW_C-1:0] st;
   ccirc_sqrt #(.TAGW(TW+QW_C)) u_sqrt (
      .clock(clock), .reset(reset), .in_valid(v6_ff), .rad(sq_ff),
      .in_tag({t6_ff, qy6_ff}), .out_valid(sv), .root(rt), .out_tag(st)
   );

   logic o_v_ff, o_dg_ff;
   logic [31:0] o_x_ff, o_y_ff;
   logic [30:0] o_r_ff;
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else o_v_ff <= sv;
      o_dg_ff <= st[TW+QW_C-1];
      o_x_ff <= st[TW+QW_C-1] ? '0 : st[2*QW_C-1:QW_C];
      o_y_ff <= st[TW+QW_C-1] ? '0 : st[QW_C-1:0];
      o_r_ff <= st[TW+QW_C-1] ? '0 : rt[30:0];
   end

   assign rsp_valid = o_v_ff;
   assign rsp_center_x = o_x_ff;
   assign rsp_center_y = o_y_ff;
   assign rsp_circle_radius = o_r_ff;
   assign rsp_degenerate = o_dg_ff;

`ifndef SYNTHESIS
   a_no_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_center_x == 0 && rsp_circle_radius == 0)
      else $error("degenerate result not zero");
   a_div_lock: assert property (@(posedge clock) disable iff (reset) dv_x == dv_y)
      else $error("dividers out of step");
`endif

endmodule

@@ sim/circumcircle_from_three_points_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// circumcircle_from_three_points_tb
// Drives point triples into the circumcircle pipeline and checks each result
// word against a circumcenter and radius computed here in exact integers.
// ---------------------------------------------------------------------------
module circumcircle_from_three_points_tb
   import ccirc_pkg::*;
();

   localparam int LIMIT_C = 2000;
   localparam int DRAIN_C = 90;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        radius;
      logic               degenerate;
   } circle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [XW_C-1:0] req_ax = '0, req_bx = '0, req_cx = '0;
   logic [YW_C-1:0] req_ay = '0, req_by_coord = '0, req_cy = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_center_x, rsp_center_y;
   logic [30:0] rsp_circle_radius;
   logic rsp_degenerate;

   circle_type expected_circles[$];
   int errors = 0;
   int idle_cycles = 0;
   int gap_left = 0;

   always #6 clock = ~clock;

   circumcircle_from_three_points dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ax(req_ax), .req_ay(req_ay), .req_bx(req_bx),
      .req_by_coord(req_by_coord), .req_cx(req_cx), .req_cy(req_cy),
      .rsp_valid(rsp_valid), .rsp_center_x(rsp_center_x),
      .rsp_center_y(rsp_center_y), .rsp_circle_radius(rsp_circle_radius),
      .rsp_degenerate(rsp_degenerate)
   );

   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] rem, root, bit_v;
      rem = v;
      root = 0;
      bit_v = 64'h4000_0000_0000_0000;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (rem >= root + bit_v) begin
            rem = rem - (root + bit_v);
            root = (root >> 1) + bit_v;
         end else begin
            root = root >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return root;
   endfunction

   function automatic circle_type circumcircle(input longint x1, y1, x2, y2, x3, y3);
      circle_type c;
      longint det, s1, s2, s3, nx, ny, qx, qy, dx, dy;
      logic [63:0] adx, ady;
      c = '0;
      det = 2 * (x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2));
      if (det == 0) begin
         c.degenerate = 1'b1;
         return c;
      end
      s1 = x1 * x1 + y1 * y1;
      s2 = x2 * x2 + y2 * y2;
      s3 = x3 * x3 + y3 * y3;
      nx = s1 * (y2 - y3) + s2 * (y3 - y1) + s3 * (y1 - y2);
      ny = s1 * (x3 - x2) + s2 * (x1 - x3) + s3 * (x2 - x1);
      qx = nx / det;
      qy = ny / det;
      dx = x1 - qx;
      dy = y1 - qy;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      c.center_x = qx[31:0];
      c.center_y = qy[31:0];
      c.radius = isqrt(adx * adx + ady * ady);
      return c;
   endfunction

   task automatic send_word(input int ax, ay, bx, by, cx, cy, input bit bursty = 1);
      if (bursty) begin
         if (gap_left == 0 && $urandom_range(0, 15) == 0) gap_left = $urandom_range(1, 12);
         while (gap_left > 0) begin
            start <= 1'b0;
            @(posedge clock);
            gap_left--;
         end
      end
      start <= 1'b1;
      req_ax <= ax; req_ay <= ay; req_bx <= bx;
      req_by_coord <= by; req_cx <= cx; req_cy <= cy;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_circles.push_back(circumcircle(ax[XW_C-1:0], ay[YW_C-1:0],
         bx[XW_C-1:0], by[YW_C-1:0], cx[XW_C-1:0], cy[YW_C-1:0]));
   endtask

   task automatic wait_empty();
      start <= 1'b0;
      @(posedge clock);
      while (expected_circles.size() != 0) @(posedge clock);
   endtask

   task automatic test_corners();
      send_word(0, 0, 639, 0, 0, 479);
      send_word(1023, 511, 0, 0, 1023, 0);
      send_word(0, 0, 1, 1, 2, 2);
      send_word(5, 5, 5, 5, 5, 5);
      send_word(0, 0, 1023, 511, 1022, 511);
      send_word(0, 0, 1, 0, 0, 1);
      send_word(1023, 511, 1023, 510, 1022, 511);
      send_word(100, 100, 300, 100, 200, 101);
      send_word(0, 511, 1023, 0, 1022, 1);
      send_word(10, 20, 10, 20, 30, 40);
      send_word(0, 0, 0, 479, 0, 200);
      send_word(320, 240, 321, 240, 1023, 511);
   endtask

   task automatic test_pause_drain();
      wait_empty();
      repeat (3) send_word(10, 10, 600, 20, 30, 400, 0);
   endtask

   task automatic test_random_triples();
      int ax, ay, bx, by, t;
      for (int i = 0; i < 1200; i++) begin
         ax = $urandom_range(0, 1023);
         ay = $urandom_range(0, 511);
         bx = $urandom_range(0, 1023);
         by = $urandom_range(0, 511);
         case ($urandom_range(0, 9))
            0: begin
               t = $urandom_range(0, 3);
               send_word(ax, ay, bx, by, ax + t * (bx - ax), ay + t * (by - ay));
            end
            1: send_word(ax, ay, ax + 1, ay, ax, ay + 1);
            2: send_word(ax, ay, bx, by, $urandom_range(0, 639), $urandom_range(0, 479));
            default: send_word(ax, ay, bx, by, $urandom_range(0, 1023),
               $urandom_range(0, 511));
         endcase
      end
   endtask

   always @(posedge clock) begin
      circle_type e;
      if (!reset && rsp_valid) begin
         if (expected_circles.size() == 0) begin
            $display("%0t: result word with none expected", $time);
            errors++;
         end else begin
            e = expected_circles.pop_front();
            if (rsp_center_x !== e.center_x || rsp_center_y !== e.center_y ||
                rsp_circle_radius !== e.radius || rsp_degenerate !== e.degenerate) begin
               $display("%0t: expected %0d %0d %0d %0b actual %0d %0d %0d %0b", $time,
                  e.center_x, e.center_y, e.radius, e.degenerate, rsp_center_x,
                  rsp_center_y, rsp_circle_radius, rsp_degenerate);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT_C) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_pause_drain();
      test_random_triples();
      wait_empty();
      repeat (DRAIN_C) @(posedge clock);
      if (errors == 0 && expected_circles.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
